// File: rtl/ring_led_effect_generator_top_assert.svh
// Assertion macros for the ring LED effect generator.
// Both macros clock on aclk; the first is gated off while aresetn is low.
`ifndef RING_LED_EFFECT_GENERATOR_TOP_ASSERT_SVH
`define RING_LED_EFFECT_GENERATOR_TOP_ASSERT_SVH

// same-cycle implication, checked out of reset only
`define RLEG_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("rleg assertion failed");

// next-cycle implication, checked during reset as well
`define RLEG_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error("rleg assertion failed");

`endif

// File: rtl/rleg_pkg.sv
package rleg_pkg;

    localparam int LED_IDX_W         = 5;
    localparam int RING_LEDS_DEF     = 30;
    localparam int PROGRESS_BITS_DEF = 16;
    localparam int COLOR_W           = 24;
    localparam int CFG_IDX_W         = 3;
    localparam int WEIGHT_W          = 9;

    // register indexes on the configuration channel
    localparam logic [CFG_IDX_W-1:0] REG_EFFECT_MODE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_COLOR     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ACCENT_COLOR   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BRIGHTNESS_PCT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_LEVEL    = 3'd4;

    // effect modes
    localparam logic [1:0] MODE_BREATH = 2'd0;
    localparam logic [1:0] MODE_METEOR = 2'd1;
    localparam logic [1:0] MODE_QUAKE  = 2'd2;

    typedef struct packed {
        logic [1:0]         mode;
        logic [COLOR_W-1:0] base;
        logic [COLOR_W-1:0] accent;
        logic [6:0]         bright;
        logic [2:0]         speed;
    } cfg_t;

    // quarter-period sine in Q1.8, entries 31 and 32 at full weight
    localparam logic [WEIGHT_W-1:0] SINE_Q8 [33] = '{
        9'd0, 9'd13, 9'd25, 9'd38, 9'd50, 9'd62, 9'd74, 9'd86, 9'd98, 9'd109,
        9'd121, 9'd132, 9'd142, 9'd152, 9'd162, 9'd172, 9'd181, 9'd190, 9'd198,
        9'd206, 9'd213, 9'd220, 9'd226, 9'd231, 9'd237, 9'd241, 9'd245, 9'd248,
        9'd251, 9'd253, 9'd255, 9'd256, 9'd256
    };

    // x positions of the ring LEDs in 0.1-unit steps
    localparam int XROM_LEN = 30;
    localparam logic [11:0] RING_X [XROM_LEN] = '{
        12'd182, 12'd486, 12'd790, 12'd1094, 12'd2006, 12'd2310, 12'd2614,
        12'd2918, 12'd3070, 12'd3070, 12'd3070, 12'd3070, 12'd3070, 12'd3070,
        12'd2918, 12'd2614, 12'd2310, 12'd2006, 12'd1702, 12'd1398, 12'd1094,
        12'd790, 12'd486, 12'd182, 12'd30, 12'd30, 12'd30, 12'd30, 12'd30, 12'd30
    };

    // x extent of the ROM is 30..3070: centre 1550, reach (3040 + 2*1000)/2
    localparam logic [11:0] QK_CENTRE = 12'd1550;
    localparam int          QK_REACH  = 2520;
    localparam logic [8:0]  QK_FADE   = 9'd500;
    // 5*reach/2 for the growing phase, 5*reach/3 for the shrinking phase
    localparam logic [13:0] QK_GROW_K   = 14'(5 * QK_REACH);
    localparam logic [12:0] QK_SHRINK_K = 13'((5 * QK_REACH) / 3);

    // reciprocals in Q.24, rounded up, exact for the value ranges used here
    localparam logic [17:0] QK_RECIP  = 18'(((1 << 24) + 124) / 125);
    localparam logic [17:0] DIM_RECIP = 18'(((1 << 24) + 99) / 100);
    localparam logic [23:0] MET_RECIP [8] = '{
        24'(((1 << 24) + 1) / 2),   24'(((1 << 24) + 4) / 5),
        24'(((1 << 24) + 7) / 8),   24'(((1 << 24) + 10) / 11),
        24'(((1 << 24) + 13) / 14), 24'(((1 << 24) + 16) / 17),
        24'(((1 << 24) + 19) / 20), 24'(((1 << 24) + 22) / 23)
    };

endpackage

// File: rtl/rleg_weight.sv
module rleg_weight #(
    parameter int RING_LEDS     = rleg_pkg::RING_LEDS_DEF,
    parameter int PROGRESS_BITS = rleg_pkg::PROGRESS_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           en,
    input  rleg_pkg::cfg_t                 cfg,
    input  logic                           in_valid,
    input  logic [rleg_pkg::LED_IDX_W-1:0] led_index,
    input  logic [PROGRESS_BITS:0]         anim_progress,
    output logic                           w_valid,
    output logic [rleg_pkg::WEIGHT_W-1:0]  weight
);
    import rleg_pkg::*;

    localparam int PB = PROGRESS_BITS;

    // stage 1 combinational
    logic              running;
    logic [5:0]        br_i;
    logic [5:0]        br_k;
    logic [PB+6:0]     head_prod;
    logic [6:0]        head;
    logic [6:0]        idx7;
    logic              met_off;
    logic [6:0]        met_d;
    logic [4:0]        met_len;
    logic [PB+3:0]     p5;
    logic [PB+14:0]    grow_prod;
    logic [PB:0]       rest;
    logic [PB+13:0]    shrink_prod;
    logic [11:0]       qk_r;
    logic              qk_off;
    logic [11:0]       qk_x;
    logic [10:0]       qk_dist;

    // stage 1 registers
    logic                s1_valid_reg;
    logic                s1_run_reg;
    logic [1:0]          s1_mode_reg;
    logic [WEIGHT_W-1:0] s1_wbr_reg;
    logic                s1_moff_reg;
    logic [6:0]          s1_d_reg;
    logic [4:0]          s1_len_reg;
    logic                s1_qoff_reg;
    logic [11:0]         s1_r_reg;
    logic [10:0]         s1_dist_reg;

    // stage 2 combinational
    logic [36:0]         met_prod;
    logic [WEIGHT_W-1:0] met_w;
    logic [8:0]          qk_diff;
    logic [32:0]         qk_prod;
    logic [WEIGHT_W-1:0] qk_w;
    logic [WEIGHT_W-1:0] w_next;

    logic                w_valid_reg;
    logic [WEIGHT_W-1:0] w_reg;

    // breathing: sine index folded about the half period
    assign running = ~anim_progress[PB];
    assign br_i    = anim_progress[PB-1 -: 6];
    assign br_k    = (br_i <= 6'd32) ? br_i : 6'(7'd64 - {1'b0, br_i});

    // meteor: head position and distance behind it
    assign head_prod = (PB+7)'(anim_progress[PB-1:0]) * (PB+7)'(RING_LEDS);
    assign head      = head_prod[PB+6:PB];
    assign idx7      = {2'b00, led_index};
    assign met_off   = (idx7 >= 7'(RING_LEDS));
    assign met_d     = (idx7 <= head) ? head - idx7 : 7'(head + 7'(RING_LEDS) - idx7);
    assign met_len   = 5'(5'd2 + 5'(cfg.speed) * 5'd3);

    // quake: wave radius and distance from the centre line
    assign p5          = (PB+4)'(anim_progress) * (PB+4)'(5);
    assign grow_prod   = (PB+15)'(anim_progress) * (PB+15)'(QK_GROW_K);
    assign rest        = (PB+1)'(1 << PB) - anim_progress;
    assign shrink_prod = (PB+14)'(rest) * (PB+14)'(QK_SHRINK_K);
    assign qk_r = (p5 < (PB+4)'(2 << PB)) ? grow_prod[PB+12:PB+1] : shrink_prod[PB+11:PB];
    assign qk_off  = (led_index >= LED_IDX_W'(XROM_LEN));
    assign qk_x    = qk_off ? QK_CENTRE : RING_X[led_index];
    assign qk_dist = (qk_x >= QK_CENTRE) ? 11'(qk_x - QK_CENTRE) : 11'(QK_CENTRE - qk_x);

    // stage 1: register per-mode terms
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (en) begin
            s1_valid_reg <= in_valid;
        end
        if (en) begin
            s1_run_reg  <= running;
            s1_mode_reg <= cfg.mode;
            s1_wbr_reg  <= SINE_Q8[br_k];
            s1_moff_reg <= met_off;
            s1_d_reg    <= met_d;
            s1_len_reg  <= met_len;
            s1_qoff_reg <= qk_off;
            s1_r_reg    <= qk_r;
            s1_dist_reg <= qk_dist;
        end
    end

    // meteor tail weight: (len-d)*256/len by reciprocal
    assign met_prod = 37'({5'(s1_len_reg - 5'(s1_d_reg)), 8'd0}) * 37'(MET_RECIP[cfg.speed]);
    always_comb begin
        if (s1_moff_reg) begin
            met_w = '0;
        end else if (s1_d_reg == 7'd0) begin
            met_w = 9'd256;
        end else if (s1_d_reg < 7'(s1_len_reg)) begin
            met_w = met_prod[32:24];
        end else begin
            met_w = '0;
        end
    end

    // quake fade band weight: (r-dist)*256/500 by reciprocal
    assign qk_diff = 9'(s1_r_reg - 12'(s1_dist_reg));
    assign qk_prod = 33'({qk_diff, 6'd0}) * 33'(QK_RECIP);
    always_comb begin
        if (s1_qoff_reg) begin
            qk_w = '0;
        end else if (13'(s1_dist_reg) + 13'(QK_FADE) <= 13'(s1_r_reg)) begin
            qk_w = 9'd256;
        end else if (12'(s1_dist_reg) <= s1_r_reg) begin
            qk_w = {1'b0, qk_prod[31:24]};
        end else begin
            qk_w = '0;
        end
    end

    // select the weight of the active mode
    always_comb begin
        w_next = '0;
        if (s1_run_reg) begin
            case (s1_mode_reg)
                MODE_BREATH: w_next = s1_wbr_reg;
                MODE_METEOR: w_next = met_w;
                MODE_QUAKE:  w_next = qk_w;
                default:     w_next = '0;
            endcase
        end
    end

    // stage 2: register the weight
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            w_valid_reg <= 1'b0;
        end else if (en) begin
            w_valid_reg <= s1_valid_reg;
        end
        if (en) begin
            w_reg <= w_next;
        end
    end

    assign w_valid = w_valid_reg;
    assign weight  = w_reg;

endmodule

// File: rtl/rleg_shade.sv
module rleg_shade (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  rleg_pkg::cfg_t                cfg,
    input  logic                          w_valid,
    input  logic [rleg_pkg::WEIGHT_W-1:0] weight,
    output logic                          out_valid,
    output logic [7:0]                    red_out,
    output logic [7:0]                    green_out,
    output logic [7:0]                    blue_out
);
    import rleg_pkg::*;

    logic [8:0]  inv_w;
    logic [6:0]  bright_sat;
    logic [16:0] mix [3];
    logic [32:0] dim_prod [3];

    logic        s3_valid_reg;
    logic [7:0]  s3_chan_reg [3];
    logic        s4_valid_reg;
    logic [14:0] s4_prod_reg [3];
    logic        s5_valid_reg;
    logic [7:0]  s5_chan_reg [3];

    assign inv_w      = 9'(9'd256 - weight);
    assign bright_sat = (cfg.bright > 7'd100) ? 7'd100 : cfg.bright;

    // blend each channel, channel 0 red
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            mix[c] = 17'(cfg.base[23-8*c -: 8]) * 17'(inv_w)
                   + 17'(cfg.accent[23-8*c -: 8]) * 17'(weight);
        end
        for (int c = 0; c < 3; c++) begin
            dim_prod[c] = 33'(s4_prod_reg[c]) * 33'(DIM_RECIP);
        end
    end

    // stages 3 to 5: blend, scale by brightness, divide by 100
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end else if (en) begin
            s3_valid_reg <= w_valid;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
        end
        if (en) begin
            for (int c = 0; c < 3; c++) begin
                s3_chan_reg[c] <= mix[c][15:8];
                s4_prod_reg[c] <= 15'(s3_chan_reg[c]) * 15'(bright_sat);
                s5_chan_reg[c] <= dim_prod[c][31:24];
            end
        end
    end

    assign out_valid = s5_valid_reg;
    assign red_out   = s5_chan_reg[0];
    assign green_out = s5_chan_reg[1];
    assign blue_out  = s5_chan_reg[2];

endmodule

// File: rtl/ring_led_effect_generator_top.sv
// Ring LED effect generator: one request (LED index, animation progress) in, one RGB colour
// out, breathing, meteor or quake effect per effect_mode, scaled by brightness_pct. The
// pipeline is five register stages (per-mode terms, weight, blend, brightness product,
// divide by 100) and takes one request per cycle while not halted; the result shows on the
// master side from the divide stage. The whole pipeline advances together and halts only
// while a result waits on the master side. Configuration writes are taken every cycle and
// must only be made while no request is in flight.
module ring_led_effect_generator_top #(
    parameter int RING_LEDS     = rleg_pkg::RING_LEDS_DEF,
    parameter int PROGRESS_BITS = rleg_pkg::PROGRESS_BITS_DEF
) (
    input  logic aclk,
    input  logic aresetn,
    // led_index, anim_progress, zero fill
    input  logic [((rleg_pkg::LED_IDX_W + PROGRESS_BITS + 8) / 8) * 8 - 1:0] s_tdata,
    input  logic s_tvalid,
    output logic s_tready,
    // red_out, green_out, blue_out
    output logic [23:0] m_tdata,
    output logic m_tvalid,
    input  logic m_tready,
    input  logic cfg_valid,
    output logic cfg_ready,
    input  logic [rleg_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rleg_pkg::COLOR_W-1:0]   cfg_data
);
    import rleg_pkg::*;

    cfg_t                 cfg_reg;
    logic                 en;
    logic                 w_valid;
    logic [WEIGHT_W-1:0]  weight;
    logic                 out_valid;
    logic [7:0]           red_out;
    logic [7:0]           green_out;
    logic [7:0]           blue_out;

    // advance the pipeline unless a result is held
    assign en        = ~out_valid | m_tready;
    assign s_tready  = en;
    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.mode   <= MODE_BREATH;
            cfg_reg.base   <= '0;
            cfg_reg.accent <= 24'hFFFFFF;
            cfg_reg.bright <= 7'd100;
            cfg_reg.speed  <= 3'd1;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_EFFECT_MODE:    cfg_reg.mode   <= cfg_data[1:0];
                REG_BASE_COLOR:     cfg_reg.base   <= cfg_data;
                REG_ACCENT_COLOR:   cfg_reg.accent <= cfg_data;
                REG_BRIGHTNESS_PCT: cfg_reg.bright <= cfg_data[6:0];
                REG_SPEED_LEVEL:    cfg_reg.speed  <= cfg_data[2:0];
                default: ;
            endcase
        end
    end

    rleg_weight #(
        .RING_LEDS     (RING_LEDS),
        .PROGRESS_BITS (PROGRESS_BITS)
    ) u_weight (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .en            (en),
        .cfg           (cfg_reg),
        .in_valid      (s_tvalid),
        .led_index     (s_tdata[LED_IDX_W-1:0]),
        .anim_progress (s_tdata[LED_IDX_W + PROGRESS_BITS:LED_IDX_W]),
        .w_valid       (w_valid),
        .weight        (weight)
    );

    rleg_shade u_shade (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .cfg       (cfg_reg),
        .w_valid   (w_valid),
        .weight    (weight),
        .out_valid (out_valid),
        .red_out   (red_out),
        .green_out (green_out),
        .blue_out  (blue_out)
    );

    assign m_tvalid = out_valid;
    assign m_tdata  = {blue_out, green_out, red_out};

`include "ring_led_effect_generator_top_assert.svh"

    `RLEG_ASSERT_NXT(a_reset_clears_out, !aresetn, !m_tvalid)
    `RLEG_ASSERT_IMP(a_ready_follows_out, 1'b1, s_tready == (!m_tvalid || m_tready))
    `RLEG_ASSERT_IMP(a_dark_when_off, m_tvalid && (cfg_reg.bright == 7'd0), m_tdata == 24'd0)

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import rleg_pkg::*;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pixel_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic [23:0] s_tdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] m_tdata;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [23:0] cfg_data = '0;

    // register mirror
    logic [1:0]  cur_mode = MODE_BREATH;
    logic [23:0] cur_base = 24'h000000;
    logic [23:0] cur_accent = 24'hFFFFFF;
    logic [6:0]  cur_bright = 7'd100;
    logic [2:0]  cur_speed = 3'd1;

    logic [23:0] pending_reqs[$];
    pixel_t      expected_pixels[$];
    int          send_idle = 0;
    int          recv_idle = 0;
    int          stall_left = 0;
    int          mismatches = 0;
    int          cycles = 0;

    ring_led_effect_generator_top DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tdata(s_tdata), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .m_tdata(m_tdata), .m_tvalid(m_tvalid), .m_tready(m_tready),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic logic [8:0] sine_at(int k);
        logic [7:0] tbl[31] = '{0, 13, 25, 38, 50, 62, 74, 86, 98, 109, 121, 132, 142,
            152, 162, 172, 181, 190, 198, 206, 213, 220, 226, 231, 237, 241, 245, 248,
            251, 253, 255};
        if (k >= 31) return 9'd256;
        return {1'b0, tbl[k]};
    endfunction

    // weight of the accent color for one LED at one progress
    function automatic int accent_weight(int idx, longint p);
        int i, len, head, d, x, dx;
        longint r;
        if (p >= 65536) return 0;
        case (cur_mode)
            MODE_BREATH: begin
                i = int'(p >> 10) & 63;
                return sine_at(i <= 32 ? i : 64 - i);
            end
            MODE_METEOR: begin
                len = 2 + 3 * cur_speed;
                head = int'((p * 30) >> 16) % 30;
                if (idx >= 30) return 0;
                d = (idx <= head) ? head - idx : head + 30 - idx;
                if (d == 0) return 256;
                if (d < len) return ((len - d) * 256) / len;
                return 0;
            end
            MODE_QUAKE: begin
                if (idx >= 30) return 0;
                // extent 30..3070: centre 1550, reach 2520
                if (p * 5 < 2 * 65536) r = (p * 5 * 2520) / (2 * 65536);
                else r = ((65536 - p) * 5 * 2520) / (3 * 65536);
                x = RING_X[idx];
                dx = (x >= 1550) ? x - 1550 : 1550 - x;
                if (dx + 500 <= r) return 256;
                if (dx <= r) return int'(((r - dx) * 256) / 500);
                return 0;
            end
            default: return 0;
        endcase
    endfunction

    function automatic logic [7:0] shade(logic [7:0] a, logic [7:0] b, int w);
        int c, br;
        c = (a * (256 - w) + b * w) >> 8;
        br = (cur_bright > 100) ? 100 : cur_bright;
        return 8'((c * br) / 100);
    endfunction

    function automatic pixel_t led_color(logic [23:0] req);
        pixel_t px;
        int w;
        w = accent_weight(req[4:0], longint'(req[21:5]));
        px.red   = shade(cur_base[23:16], cur_accent[23:16], w);
        px.green = shade(cur_base[15:8], cur_accent[15:8], w);
        px.blue  = shade(cur_base[7:0], cur_accent[7:0], w);
        return px;
    endfunction

    // apply configuration transfers to the mirror
    always @(posedge aclk) begin
        if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_EFFECT_MODE:    cur_mode = cfg_data[1:0];
                REG_BASE_COLOR:     cur_base = cfg_data;
                REG_ACCENT_COLOR:   cur_accent = cfg_data;
                REG_BRIGHTNESS_PCT: cur_bright = cfg_data[6:0];
                REG_SPEED_LEVEL:    cur_speed = cfg_data[2:0];
                default: ;
            endcase
            cfg_valid <= 1'b0;
        end
    end

    // drive requests, predict each transfer
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                expected_pixels.push_back(led_color(s_tdata));
            if (!s_tvalid || s_tready) begin
                if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle) begin
                    s_tdata <= pending_reqs.pop_front();
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // check results, drive ready
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_pixels.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result %h", m_tdata);
                end else begin
                    pixel_t want;
                    want = expected_pixels.pop_front();
                    if (m_tdata[7:0] !== want.red || m_tdata[15:8] !== want.green ||
                        m_tdata[23:16] !== want.blue) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("rgb mismatch: expected %h %h %h, got %h %h %h",
                                want.red, want.green, want.blue,
                                m_tdata[7:0], m_tdata[15:8], m_tdata[23:16]);
                    end
                end
            end
            if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left <= stall_left - 1;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_idle);
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > 400000) begin
            $display("tb_top: errors");
            $finish;
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [23:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        while (cfg_valid) @(posedge aclk);
    endtask

    task automatic set_all(logic [1:0] mode, logic [23:0] base, logic [23:0] accent,
                           logic [6:0] bright, logic [2:0] speed);
        write_reg(REG_EFFECT_MODE, {22'd0, mode});
        write_reg(REG_BASE_COLOR, base);
        write_reg(REG_ACCENT_COLOR, accent);
        write_reg(REG_BRIGHTNESS_PCT, {17'd0, bright});
        write_reg(REG_SPEED_LEVEL, {21'd0, speed});
    endtask

    task automatic queue_req(logic [4:0] idx, logic [16:0] p);
        pending_reqs.push_back({2'b00, p, idx});
    endtask

    // wait out every pending result and the pipeline depth
    task automatic drain();
        while (pending_reqs.size() > 0 || s_tvalid || expected_pixels.size() > 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    initial begin
        logic [16:0] p;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        // breathing at reset values: sine peak, finished and overrange progress
        queue_req(0, 0); queue_req(31, 17'd16384); queue_req(5, 17'd32768);
        queue_req(7, 17'd65535); queue_req(1, 17'd65536); queue_req(2, 17'h1FFFF);
        drain();
        // meteor, long and short tails, LEDs off the ring
        set_all(MODE_METEOR, 24'h102030, 24'hF0E0D0, 7'd127, 3'd7);
        queue_req(0, 0); queue_req(29, 0); queue_req(30, 17'd1000);
        queue_req(31, 17'd65535); queue_req(28, 17'd65535); queue_req(10, 17'd30000);
        drain();
        write_reg(REG_SPEED_LEVEL, 24'd0);
        queue_req(29, 0); queue_req(28, 0);
        drain();
        // quake around its turning point, unused mode, zero brightness
        set_all(MODE_QUAKE, 24'hFFFFFF, 24'h000000, 7'd100, 3'd1);
        queue_req(0, 17'd26214); queue_req(8, 17'd26214); queue_req(24, 17'd40000);
        queue_req(31, 17'd26214); queue_req(15, 0); queue_req(12, 17'd65535);
        drain();
        set_all(2'd3, 24'hABCDEF, 24'h123456, 7'd0, 3'd6);
        queue_req(3, 17'd1234); queue_req(4, 17'd65536);
        drain();

        for (int regime = 0; regime < 3; regime++) begin
            send_idle = (regime == 0) ? 7 : (regime == 1) ? 73 : 0;
            recv_idle = (regime == 0) ? 73 : (regime == 1) ? 7 : 0;
            for (int ph = 0; ph < 8; ph++) begin
                if (ph == 0)
                    set_all(MODE_BREATH, 24'h000000, 24'h000000, 7'd0, 3'd0);
                else if (ph == 1)
                    set_all(2'd3, 24'hFFFFFF, 24'hFFFFFF, 7'd127, 3'd7);
                else
                    set_all(2'($urandom_range(ph % 4 == 3 ? 3 : 2)),
                            24'($urandom), 24'($urandom),
                            7'($urandom_range(9) == 0 ? $urandom_range(127)
                                                      : $urandom_range(100)),
                            3'($urandom_range(9) == 0 ? $urandom_range(7)
                                                      : $urandom_range(5, 1)));
                if (ph == 4 && regime == 2) stall_left = 200;
                for (int n = 0; n < 64; n++) begin
                    p = ($urandom_range(9) == 0) ? 17'($urandom_range(131071, 65536))
                                                 : 17'($urandom_range(65535));
                    queue_req(5'($urandom_range(31)), p);
                end
                drain();
            end
        end

        if (mismatches == 0 && expected_pixels.size() == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule
